// File: sv/bipa_pkg.sv
// Package for the batched id pool allocator: operation codes, status codes and widths.
// Used by bipa_divider, batched_id_pool_allocator_core and bipa_checker; depends on nothing.
package bipa_pkg;

	localparam int unsigned IdW = 28;
	localparam int unsigned BsW = 13;
	localparam int unsigned PlayerW = 10;
	localparam int unsigned BidxW = 16;
	localparam int unsigned TotalW = 20;

	typedef enum logic [2:0] {
		OP_ASSIGN = 3'd0,
		OP_TAKE   = 3'd1,
		OP_FIND   = 3'd2,
		OP_FEED_C = 3'd3,
		OP_FEED_S = 3'd4,
		OP_REQ    = 3'd5,
		OP_CLEAR  = 3'd6,
		OP_NONE   = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2,
		ST_RSVD  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		REG_BATCH_SIZE = 3'd0,
		REG_MIN_AVAIL  = 3'd1,
		REG_IN_FLIGHT  = 3'd2,
		REG_SERVER     = 3'd3,
		REG_CLIENT     = 3'd4
	} reg_t;

endpackage

// File: sv/bipa_divider.sv
// Restoring divider, one quotient bit per cycle, for 28-bit dividends by a 13-bit divisor.
// Uses bipa_pkg for widths.
module bipa_divider (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [bipa_pkg::IdW-1:0] dividend,
	input  logic [bipa_pkg::BsW-1:0] divisor,
	output logic                     done,
	output logic [bipa_pkg::IdW-1:0] quotient
);
	logic [bipa_pkg::BsW:0]   rem_q;
	logic [bipa_pkg::IdW-1:0] quo_q;
	logic [4:0]               cnt_q;
	logic                     busy_q;
	logic [bipa_pkg::BsW:0]   trial;
	logic [bipa_pkg::BsW:0]   diff;

	assign trial = {rem_q[bipa_pkg::BsW-1:0], quo_q[bipa_pkg::IdW-1]};
	assign diff  = trial - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'(bipa_pkg::IdW - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
				cnt_q <= cnt_q - 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			if (!diff[bipa_pkg::BsW]) begin
				rem_q <= diff;
				quo_q <= {quo_q[bipa_pkg::IdW-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[bipa_pkg::IdW-2:0], 1'b0};
			end
		end
	end

	assign quotient = quo_q;
endmodule

// File: sv/batched_id_pool_allocator_core.sv
// Top level of the batched id pool allocator: sequencer, stores and result register.
// Depends on bipa_pkg and bipa_divider.
//
// Usage: commands arrive on the s_axis channel (tuser = kind, tdata = other fields);
// one result per command leaves on m_axis. Registers are written on the cfg channel
// (index 0 batch size, 1 minimum ids, 2 batches in flight, 3 server, 4 client); the user
// must write them only while no command is in progress, as the block does not enforce it.
// Flow: assign, take, feed, clear and the unused kind go from acceptance through the execute
// state to the output state, then back to idle. Find owner of a scene id answers with the
// server; otherwise it runs the shared bit-serial divider and then walks the received list
// one entry a cycle, or reads the owner store when the received list is empty. Request count
// passes through a multiply state and a compare state, and it runs the divide only when the
// ids left in the pool fall short of the minimum.
// The block takes one command at a time; s_axis_tready is low from acceptance until
// the result has been taken on m_axis. A stalled receiver holds the result register
// and so holds the block. Reset empties all stores and restores register defaults;
// store contents are not cleared, only their fill counts.
module batched_id_pool_allocator_core #(
	parameter int unsigned AVAIL_DEPTH    = 16,
	parameter int unsigned OWNER_DEPTH    = 256,
	parameter int unsigned RECEIVED_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// tdata: player[9:0], batch_index[25:10], id_value[53:26], is_scene_id[54], zero[55]
	input  logic [55:0] s_axis_tdata,
	// tuser: kind[2:0]
	input  logic [2:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// tdata: status[1:0], value[29:2], owner[39:30], owner_known[40], zero[47:41]
	output logic [47:0] m_axis_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	localparam int unsigned AW = (AVAIL_DEPTH > 1) ? $clog2(AVAIL_DEPTH) : 1;
	localparam int unsigned OW = (OWNER_DEPTH > 1) ? $clog2(OWNER_DEPTH) : 1;
	localparam int unsigned RW = (RECEIVED_DEPTH > 1) ? $clog2(RECEIVED_DEPTH) : 1;

	typedef enum logic [2:0] {
		S_IDLE, S_EXEC, S_DIV, S_SEARCH, S_REQ_MUL, S_REQ_SUB, S_OUT
	} state_t;

	state_t state_q;

	logic [bipa_pkg::BsW-1:0]     bsize_q;
	logic [15:0]                  min_q;
	logic [7:0]                   flight_q;
	logic [bipa_pkg::PlayerW-1:0] server_q;
	logic [bipa_pkg::PlayerW-1:0] client_q;

	logic [bipa_pkg::IdW-1:0] af_mem [AVAIL_DEPTH];
	logic [bipa_pkg::BsW-1:0] ac_mem [AVAIL_DEPTH];
	logic [bipa_pkg::PlayerW-1:0] own_mem [OWNER_DEPTH];
	logic [bipa_pkg::BidxW-1:0] rcv_mem [RECEIVED_DEPTH];

	logic [AW-1:0]               head_q;
	logic [AW:0]                 used_q;
	logic [bipa_pkg::TotalW-1:0] total_q;
	logic [OW:0]                 ofill_q;
	logic [RW:0]                 rfill_q;

	logic [2:0]                   kind_q;
	logic [bipa_pkg::PlayerW-1:0] player_q;
	logic [bipa_pkg::BidxW-1:0]   bidx_q;
	logic [bipa_pkg::IdW-1:0]     idv_q;
	logic                         scene_q;

	logic [1:0]                   st_q;
	logic [bipa_pkg::IdW-1:0]     val_q;
	logic [bipa_pkg::PlayerW-1:0] own_q;
	logic                         known_q;

	logic [bipa_pkg::IdW-1:0]     hf_q;
	logic [bipa_pkg::BsW-1:0]     hc_q;
	logic [bipa_pkg::PlayerW-1:0] ord_q;
	logic [bipa_pkg::BidxW-1:0]   rrd_q;
	logic [RW:0]                  sidx_q;
	logic                         rrd_ok_q;
	logic [bipa_pkg::IdW-1:0]     quo_q;
	logic [31:0]                  left_q;

	logic [bipa_pkg::BsW-1:0] bs;
	logic                     div_start;
	logic                     div_done;
	logic [bipa_pkg::IdW-1:0] div_quo;
	logic [bipa_pkg::IdW-1:0] div_dvd;
	logic [AW-1:0]            tail;
	logic [bipa_pkg::IdW-1:0] prod;
	logic                     push_en;
	logic [bipa_pkg::IdW-1:0] push_first;
	logic [bipa_pkg::BsW-1:0] push_cnt;
	logic [bipa_pkg::IdW:0]   tail_sum;

	assign bs = (bsize_q == '0) ? bipa_pkg::BsW'(1) : bsize_q;
	assign tail_sum = (bipa_pkg::IdW+1)'(head_q) + (bipa_pkg::IdW+1)'(used_q);
	assign tail = (AVAIL_DEPTH & (AVAIL_DEPTH - 1)) == 0 ? AW'(tail_sum) :
		AW'(tail_sum >= (bipa_pkg::IdW+1)'(AVAIL_DEPTH) ?
			tail_sum - (bipa_pkg::IdW+1)'(AVAIL_DEPTH) : tail_sum);
	assign prod = bipa_pkg::IdW'(bipa_pkg::IdW'(bidx_q) * bipa_pkg::IdW'(bs));

	assign s_axis_tready = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign m_axis_tvalid = (state_q == S_OUT);
	assign m_axis_tdata = {7'd0, known_q, own_q, val_q, st_q};

	// The divider samples its dividend on the start cycle, so it is formed directly.
	assign div_dvd = (kind_q == bipa_pkg::OP_REQ) ?
		bipa_pkg::IdW'(32'(min_q) - left_q - 32'd1) : idv_q;

	bipa_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_dvd),
		.divisor(bs), .done(div_done), .quotient(div_quo)
	);

	// Registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bsize_q  <= bipa_pkg::BsW'(64);
			min_q    <= 16'd100;
			flight_q <= '0;
			server_q <= '0;
			client_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				bipa_pkg::REG_BATCH_SIZE: bsize_q  <= cfg_data[bipa_pkg::BsW-1:0];
				bipa_pkg::REG_MIN_AVAIL:  min_q    <= cfg_data;
				bipa_pkg::REG_IN_FLIGHT:  flight_q <= cfg_data[7:0];
				bipa_pkg::REG_SERVER:     server_q <= cfg_data[bipa_pkg::PlayerW-1:0];
				bipa_pkg::REG_CLIENT:     client_q <= cfg_data[bipa_pkg::PlayerW-1:0];
				default: ;
			endcase
		end
	end

	// Feed decision, used in S_EXEC.
	always_comb begin
		push_en = 1'b0;
		push_first = prod;
		push_cnt = bs;
		if (kind_q == bipa_pkg::OP_FEED_C) begin
			push_en = (rfill_q < (RW+1)'(RECEIVED_DEPTH)) && (used_q < (AW+1)'(AVAIL_DEPTH));
		end else if (kind_q == bipa_pkg::OP_FEED_S) begin
			if (bidx_q == '0) begin
				push_first = bipa_pkg::IdW'(1);
				push_cnt = bs - bipa_pkg::BsW'(1);
			end
			push_en = (used_q < (AW+1)'(AVAIL_DEPTH)) && (push_cnt != '0);
		end
	end

	assign div_start = (state_q == S_EXEC &&
		(kind_q == bipa_pkg::OP_FIND && !scene_q)) || (state_q == S_REQ_SUB &&
		left_q < 32'(min_q));

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && s_axis_tvalid) begin
			hf_q <= af_mem[head_q];
			hc_q <= ac_mem[head_q];
		end
		if (state_q == S_EXEC && kind_q == bipa_pkg::OP_ASSIGN &&
				ofill_q < (OW+1)'(OWNER_DEPTH))
			own_mem[OW'(ofill_q)] <= player_q;
		if (state_q == S_EXEC && kind_q == bipa_pkg::OP_TAKE && used_q != '0) begin
			af_mem[head_q] <= hf_q + bipa_pkg::IdW'(1);
			ac_mem[head_q] <= hc_q - bipa_pkg::BsW'(1);
		end
		if (state_q == S_EXEC && push_en) begin
			af_mem[tail] <= push_first;
			ac_mem[tail] <= push_cnt;
		end
		if (state_q == S_EXEC && kind_q == bipa_pkg::OP_FEED_C && push_en)
			rcv_mem[RW'(rfill_q)] <= bidx_q;
		if (state_q == S_REQ_MUL)
			left_q <= 32'(total_q) + 32'(bs) * 32'(flight_q);
		if (div_done)
			quo_q <= div_quo;
		ord_q <= own_mem[OW'(div_done ? div_quo : quo_q)];
		rrd_q <= rcv_mem[RW'(sidx_q)];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			head_q   <= '0;
			used_q   <= '0;
			total_q  <= '0;
			ofill_q  <= '0;
			rfill_q  <= '0;
			sidx_q   <= '0;
			rrd_ok_q <= 1'b0;
			kind_q   <= '0;
			player_q <= '0;
			bidx_q   <= '0;
			idv_q    <= '0;
			scene_q  <= 1'b0;
			st_q     <= '0;
			val_q    <= '0;
			own_q    <= '0;
			known_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						kind_q   <= s_axis_tuser;
						player_q <= s_axis_tdata[9:0];
						bidx_q   <= s_axis_tdata[25:10];
						idv_q    <= s_axis_tdata[53:26];
						scene_q  <= s_axis_tdata[54];
						state_q  <= S_EXEC;
					end
				end
				S_EXEC: begin
					st_q    <= bipa_pkg::ST_OK;
					val_q   <= '0;
					own_q   <= '0;
					known_q <= 1'b0;
					state_q <= S_OUT;
					unique case (kind_q)
						bipa_pkg::OP_ASSIGN: begin
							if (ofill_q >= (OW+1)'(OWNER_DEPTH)) begin
								st_q <= bipa_pkg::ST_FULL;
							end else begin
								val_q   <= bipa_pkg::IdW'(ofill_q);
								ofill_q <= ofill_q + 1'b1;
							end
						end
						bipa_pkg::OP_TAKE: begin
							if (used_q == '0) begin
								st_q <= bipa_pkg::ST_EMPTY;
							end else begin
								val_q <= hf_q;
								if (total_q != '0) total_q <= total_q - 1'b1;
								if (hc_q <= bipa_pkg::BsW'(1)) begin
									head_q <= (AW'(head_q + 1'b1) ==
										AW'(AVAIL_DEPTH)) ? '0 : AW'(head_q + 1'b1);
									used_q <= used_q - 1'b1;
								end
							end
						end
						bipa_pkg::OP_FIND: begin
							if (scene_q) begin
								own_q   <= server_q;
								known_q <= 1'b1;
							end else begin
								state_q <= S_DIV;
							end
						end
						bipa_pkg::OP_FEED_C, bipa_pkg::OP_FEED_S: begin
							if (push_en) begin
								used_q  <= used_q + 1'b1;
								total_q <= total_q + bipa_pkg::TotalW'(push_cnt);
								if (kind_q == bipa_pkg::OP_FEED_C)
									rfill_q <= rfill_q + 1'b1;
							end else if (used_q >= (AW+1)'(AVAIL_DEPTH) ||
									(kind_q == bipa_pkg::OP_FEED_C)) begin
								st_q <= bipa_pkg::ST_FULL;
							end
						end
						bipa_pkg::OP_REQ: state_q <= S_REQ_MUL;
						bipa_pkg::OP_CLEAR: begin
							head_q  <= '0;
							used_q  <= '0;
							total_q <= '0;
							ofill_q <= '0;
							rfill_q <= '0;
						end
						default: ;
					endcase
				end
				S_REQ_MUL: state_q <= S_REQ_SUB;
				S_REQ_SUB: begin
					if (left_q >= 32'(min_q)) state_q <= S_OUT;
					else state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_done) begin
						if (kind_q == bipa_pkg::OP_REQ) begin
							val_q   <= div_quo + bipa_pkg::IdW'(1);
							state_q <= S_OUT;
						end else begin
							sidx_q   <= '0;
							rrd_ok_q <= 1'b0;
							state_q  <= S_SEARCH;
						end
					end
				end
				S_SEARCH: begin
					// The read is registered: rrd_q holds entry sidx_q - 1.
					if (rfill_q != '0) begin
						known_q <= 1'b1;
						if (rrd_ok_q && bipa_pkg::IdW'(rrd_q) == quo_q) begin
							own_q   <= client_q;
							state_q <= S_OUT;
						end else if (sidx_q >= rfill_q ||
								sidx_q >= (RW+1)'(RECEIVED_DEPTH)) begin
							own_q   <= server_q;
							state_q <= S_OUT;
						end else begin
							sidx_q   <= sidx_q + 1'b1;
							rrd_ok_q <= 1'b1;
						end
					end else begin
						if (quo_q < bipa_pkg::IdW'(ofill_q) &&
								quo_q < bipa_pkg::IdW'(OWNER_DEPTH)) begin
							own_q   <= ord_q;
							known_q <= 1'b1;
						end
						state_q <= S_OUT;
					end
				end
				S_OUT: if (m_axis_tready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// File: sv/bipa_checker.sv
// Port-level checker for the batched id pool allocator, bound to the top level.
// Depends on bipa_pkg for status codes.
module bipa_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [47:0] m_axis_tdata
);
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready) else $error("input taken while result pending");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result dropped under stall");
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[1:0] != bipa_pkg::ST_RSVD)
		else $error("reserved status");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("ready while busy");
endmodule

bind batched_id_pool_allocator_core bipa_checker u_chk (
	.clk(clk), .arst_n(arst_n), .s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
